[src/dpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the demand paging translator
// Sizes of the virtual and physical spaces, request kinds, result codes and
// the control state encoding.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned FRAME_COUNT = 16;
  localparam int unsigned PAGE_COUNT  = 32;

  // field widths of the transaction payloads
  localparam int REQ_W  = 2;
  localparam int VA_W   = 20;
  localparam int ST_W   = 3;
  localparam int PA_W   = 16;
  localparam int FIDX_W = 4;

  localparam int OFFSET_W = $clog2(PAGE_BYTES);
  localparam int FRAME_W  = $clog2(FRAME_COUNT);
  localparam int PAGE_W   = $clog2(PAGE_COUNT);
  localparam int PN_W     = VA_W - OFFSET_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_ACCESS    = 2'd0,
    REQ_TRANSLATE = 2'd1,
    REQ_RELEASE   = 2'd2,
    REQ_RESERVED  = 2'd3
  } req_kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_HIT           = 3'd0,
    ST_ALLOC         = 3'd1,
    ST_FAULT         = 3'd2,
    ST_FULL          = 3'd3,
    ST_RANGE         = 3'd4,
    ST_FREED         = 3'd5,
    ST_FREE_UNMAPPED = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

endpackage
`default_nettype wire

[src/dpt_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_req_if: request channel
// Valid/ready channel carrying the request kind and the virtual address.
// ----------------------------------------------------------------------------
interface dpt_req_if import dpt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VA_W-1:0]  virtual_address;

  modport source (output valid, output req_type, output virtual_address, input ready);
  modport sink (input valid, input req_type, input virtual_address, output ready);
endinterface
`default_nettype wire

[src/dpt_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_rsp_if: response channel
// Valid/ready channel carrying the status, physical address and frame.
// ----------------------------------------------------------------------------
interface dpt_rsp_if import dpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [PA_W-1:0]   physical_address;
  logic [FIDX_W-1:0] frame_index;

  modport source (output valid, output status, output physical_address,
                  output frame_index, input ready);
  modport sink (input valid, input status, input physical_address,
                input frame_index, output ready);
endinterface
`default_nettype wire

[src/demand_paging_translator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_translator: single-level page table with demand allocation
// Translates virtual addresses through a page table held in a synchronous
// memory; unmapped pages get the lowest-numbered free frame on an access.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request transactions (req_type, virtual_address), valid/ready.
//   rsp  : one response transaction per request (status, physical_address,
//          frame_index), valid/ready.
//   At the accept edge the request is captured and the page table read is
//   issued; in the lookup state the registered frame number decides the
//   outcome, and the commit writes back the table and frame map and loads
//   the output register. A new request is not accepted while the lookup of
//   the last one is pending. rsp.valid comes from the output register and
//   is set at the commit.
//   Reset (rst, synchronous) marks every page unmapped and every frame free
//   at once through per-page valid flops; no clearing pass is needed.
//   When the receiver stalls, the pending response holds in the output
//   register; the next request is still accepted and read, and it waits in
//   the lookup state until the output register is free.
// ----------------------------------------------------------------------------
module demand_paging_translator import dpt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  dpt_req_if.sink    req,
  dpt_rsp_if.source  rsp
);

  state_t state, state_next;

  // request held during the lookup
  logic [REQ_W-1:0]    kind_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [PAGE_W-1:0]   page_q;
  logic                range_ok_q;

  // page table: frame numbers in memory, valid bits in flops
  logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
  logic [FRAME_W-1:0]    rd_frame;
  logic [PAGE_COUNT-1:0] page_valid;
  logic [FRAME_COUNT-1:0] frame_busy;

  // output register
  logic              out_valid;
  logic [ST_W-1:0]   out_status;
  logic [PA_W-1:0]   out_pa;
  logic [FIDX_W-1:0] out_fr;

  logic [PN_W-1:0]     in_page_field;
  logic [31:0]         in_page_ext;
  logic                in_range_ok;
  logic                req_fire;
  logic                commit;
  logic                free_found;
  logic [FRAME_W-1:0]  free_idx;
  logic [FRAME_W-1:0]  use_frame;
  logic                do_alloc;
  logic                do_release;
  status_t             res_status;
  logic                res_xlate;

  assign in_page_field = req.virtual_address[VA_W-1:OFFSET_W];
  assign in_page_ext   = {{(32-PN_W){1'b0}}, in_page_field};
  assign in_range_ok   = in_page_ext < PAGE_COUNT;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign commit    = (state == S_LOOK) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // capture the request and issue the table read
  always_ff @(posedge clk) begin
    if (req_fire) begin
      kind_q     <= req.req_type;
      offset_q   <= req.virtual_address[OFFSET_W-1:0];
      page_q     <= in_page_field[PAGE_W-1:0];
      range_ok_q <= in_range_ok;
      rd_frame   <= frame_mem[in_page_field[PAGE_W-1:0]];
    end
  end

  // lowest free frame
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!frame_busy[i]) begin
        free_found = 1'b1;
        free_idx   = FRAME_W'(i);
      end
    end
  end

  always_comb begin
    do_alloc   = 1'b0;
    do_release = 1'b0;
    res_xlate  = 1'b0;
    use_frame  = rd_frame;
    res_status = ST_RANGE;
    if (!range_ok_q) begin
      res_status = ST_RANGE;
    end else if (kind_q == REQ_RELEASE) begin
      if (page_valid[page_q]) begin
        res_status = ST_FREED;
        do_release = 1'b1;
      end else begin
        res_status = ST_FREE_UNMAPPED;
      end
    end else if (page_valid[page_q]) begin
      res_status = ST_HIT;
      res_xlate  = 1'b1;
    end else if (kind_q != REQ_ACCESS) begin
      res_status = ST_FAULT;
    end else if (free_found) begin
      res_status = ST_ALLOC;
      res_xlate  = 1'b1;
      do_alloc   = 1'b1;
      use_frame  = free_idx;
    end else begin
      res_status = ST_FULL;
    end
  end

  // table and frame map write back
  always_ff @(posedge clk) begin
    if (commit && do_alloc) begin
      frame_mem[page_q] <= free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      frame_busy <= '0;
    end else if (commit) begin
      if (do_alloc) begin
        page_valid[page_q]   <= 1'b1;
        frame_busy[free_idx] <= 1'b1;
      end else if (do_release) begin
        page_valid[page_q]   <= 1'b0;
        frame_busy[rd_frame] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= res_status;
      out_pa     <= res_xlate ? PA_W'({use_frame, offset_q}) : '0;
      out_fr     <= (res_xlate || do_release) ? FIDX_W'(use_frame) : '0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.physical_address = out_pa;
  assign rsp.frame_index      = out_fr;

  // every mapped page owns exactly one busy frame
  a_map_balance: assert property (@(posedge clk) disable iff (rst)
    $countones(page_valid) == $countones(frame_busy))
    else $error("mapped page count differs from busy frame count");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    commit && do_alloc |=> $countones(frame_busy) == $past($countones(frame_busy)) + 1)
    else $error("allocation did not take a frame");

  a_release_shrinks: assert property (@(posedge clk) disable iff (rst)
    commit && do_release |=> $countones(frame_busy) == $past($countones(frame_busy)) - 1)
    else $error("release did not free a frame");

  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == S_LOOK)
    else $error("accepted transaction did not enter lookup");

  a_no_xlate_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_HIT && out_status != ST_ALLOC |-> out_pa == '0)
    else $error("physical address set without a translation");

endmodule
`default_nettype wire

[bench/demand_paging_translator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_translator_test: self-checking bench for the page translator
// Drives request transactions (a directed table, then random traffic with
// idle gaps on both channels) and checks every response against the directed
// table's expected result or a local page table model that tracks mappings and frame usage.
// ----------------------------------------------------------------------------
module demand_paging_translator_test;
  import dpt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [PA_W-1:0]    phys;
    logic [FIDX_W-1:0]  frame;
  } xlat_result_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [VA_W-1:0]   va;
    bit                golden;
    xlat_result_t      want;
  } stim_row_t;

  localparam xlat_result_t NO_GOLDEN = '{ST_HIT, 16'h0000, 4'h0};
  localparam int DIRECTED_N = 25;
  localparam int RANDOM_N = 400;
  localparam int CHUNK_N = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dpt_req_if req_ch();
  dpt_rsp_if rsp_ch();

  demand_paging_translator dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // local copy of the page table and frame map
  bit                 page_mapped [PAGE_COUNT];
  logic [FRAME_W-1:0] page_frame  [PAGE_COUNT];
  bit                 frame_taken [FRAME_COUNT];

  xlat_result_t pending_results [$];
  int           error_count = 0;
  bit           quiet_phase = 1'b0;
  stim_row_t    directed_rows [DIRECTED_N];

  task automatic note_error(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic xlat_result_t translate_predict(req_kind_t kind,
                                                     logic [VA_W-1:0] va);
    xlat_result_t        r;
    logic [PN_W-1:0]     page;
    logic [PAGE_W-1:0]   pidx;
    logic [OFFSET_W-1:0] offset;
    bit                  found;
    page   = va[VA_W-1:OFFSET_W];
    offset = va[OFFSET_W-1:0];
    r      = '{ST_RANGE, '0, '0};
    found  = 1'b0;
    if (int'(page) >= PAGE_COUNT) return r;
    pidx = page[PAGE_W-1:0];
    if (kind == REQ_RELEASE) begin
      if (page_mapped[pidx]) begin
        r = '{ST_FREED, '0, FIDX_W'(page_frame[pidx])};
        frame_taken[page_frame[pidx]] = 1'b0;
        page_mapped[pidx] = 1'b0;
        page_frame[pidx] = '0;
      end else begin
        r = '{ST_FREE_UNMAPPED, '0, '0};
      end
      return r;
    end
    if (page_mapped[pidx]) begin
      return '{ST_HIT, PA_W'(int'(page_frame[pidx]) * PAGE_BYTES + int'(offset)),
               FIDX_W'(page_frame[pidx])};
    end
    // translate-only and the reserved kind never allocate
    if (kind != REQ_ACCESS) return '{ST_FAULT, '0, '0};
    r = '{ST_FULL, '0, '0};
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (!found && !frame_taken[i]) begin
        found = 1'b1;
        frame_taken[i] = 1'b1;
        page_mapped[pidx] = 1'b1;
        page_frame[pidx] = FRAME_W'(i);
        r = '{ST_ALLOC, PA_W'(i * PAGE_BYTES + int'(offset)), FIDX_W'(i)};
      end
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones; none in a quiet phase
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_request(req_kind_t kind, logic [VA_W-1:0] va, bit golden,
                              xlat_result_t want);
    int           gap;
    xlat_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.virtual_address <= va;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = translate_predict(kind, va);
    pending_results.push_back(golden ? want : predicted);
  endtask

  // sender holds off until every outstanding response is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_result();
    xlat_result_t want;
    if (pending_results.size() == 0) begin
      note_error($sformatf("response with nothing outstanding, status %0d",
                           rsp_ch.status));
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.status !== want.status)
      note_error($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
    if (rsp_ch.physical_address !== want.phys)
      note_error($sformatf("physical_address %h, expected %h",
                           rsp_ch.physical_address, want.phys));
    if (rsp_ch.frame_index !== want.frame)
      note_error($sformatf("frame_index %0d, expected %0d",
                           rsp_ch.frame_index, want.frame));
  endtask

  // response side: check accepted transactions, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_result();
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("demand_paging_translator_test: errors");
    $finish;
  end

  initial begin
    req_kind_t       kind;
    logic [VA_W-1:0] va;
    int              r;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_ACCESS;
    req_ch.virtual_address <= '0;
    directed_rows = '{
      '{REQ_TRANSLATE, 20'h00000, 1'b1, '{ST_FAULT, 16'h0000, 4'h0}},
      '{REQ_RELEASE,   20'h00000, 1'b1, '{ST_FREE_UNMAPPED, 16'h0000, 4'h0}},
      '{REQ_ACCESS,    20'h00000, 1'b1, '{ST_ALLOC, 16'h0000, 4'h0}},
      '{REQ_ACCESS,    20'h00FFF, 1'b1, '{ST_HIT, 16'h0FFF, 4'h0}},
      '{REQ_ACCESS,    20'h1F123, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h20000, 1'b1, '{ST_RANGE, 16'h0000, 4'h0}},
      '{REQ_RELEASE,   20'hFFFFF, 1'b1, '{ST_RANGE, 16'h0000, 4'h0}},
      '{REQ_RESERVED,  20'h1F800, 1'b0, NO_GOLDEN},
      // fill every remaining frame, the last one at the top offset
      '{REQ_ACCESS,    20'h02001, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h03555, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h04AAA, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h05123, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h06800, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h07010, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h08F0F, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h09F00, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0A00F, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0B333, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0CCCC, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0D777, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0E888, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h0FFFF, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h10321, 1'b1, '{ST_FULL, 16'h0000, 4'h0}},
      '{REQ_RELEASE,   20'h1F000, 1'b0, NO_GOLDEN},
      '{REQ_ACCESS,    20'h10321, 1'b0, NO_GOLDEN}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].va,
                   directed_rows[i].golden, directed_rows[i].want);
    drain_results();

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n % CHUNK_N == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_N / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 45)      kind = REQ_ACCESS;
      else if (r < 65) kind = REQ_TRANSLATE;
      else if (r < 92) kind = REQ_RELEASE;
      else             kind = REQ_RESERVED;
      if ($urandom_range(0, 99) < 6)
        va = VA_W'($urandom_range(PAGE_COUNT * PAGE_BYTES, (1 << VA_W) - 1));
      else
        va = {PN_W'($urandom_range(0, PAGE_COUNT - 1)),
              OFFSET_W'($urandom_range(0, PAGE_BYTES - 1))};
      send_request(kind, va, 1'b0, NO_GOLDEN);
    end
    quiet_phase = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("demand_paging_translator_test: clean");
    else
      $display("demand_paging_translator_test: errors");
    $finish;
  end

endmodule
